// ===== design/dcfp_pkg.sv =====
// dcfp_pkg: shared constants and chain mapping functions for the dac chain frame packer
// no dependencies; used by dac_chain_frame_packer_unit
`default_nettype none

package dcfp_pkg;

   localparam int unsigned NUM_CHANNELS = 18;
   localparam int unsigned NUM_CHAINS   = 6;
   localparam int unsigned MAX_SLOTS    = 5;
   localparam int unsigned CHAN_W       = 5;
   localparam int unsigned CHAIN_W      = $clog2(NUM_CHAINS);
   localparam int unsigned VALUE_W      = 16;
   localparam int unsigned VALUE_BITS   = 10;
   localparam int unsigned ADDR_BITS    = 4;
   localparam int unsigned WORD_BITS    = VALUE_BITS + ADDR_BITS;
   localparam int unsigned IDX_W        = $clog2(NUM_CHANNELS);
   localparam int unsigned SLOT_W       = $clog2(MAX_SLOTS + 1);
   localparam int unsigned WBIT_W       = $clog2(WORD_BITS);
   localparam int unsigned BYTE_IDX_W   = 4;
   localparam int unsigned PAD_W        = 3;

   // chain index for a channel in 1..18
   function automatic logic [CHAIN_W-1:0] chain_of(input logic [CHAN_W-1:0] ch);
      logic [CHAN_W-1:0] chm1;
      chm1 = ch - CHAN_W'(1);
      if (ch <= CHAN_W'(8)) begin
         chain_of = chm1[CHAIN_W:1];
      end else if (ch <= CHAN_W'(13)) begin
         chain_of = CHAIN_W'(4);
      end else begin
         chain_of = CHAIN_W'(5);
      end
   endfunction

   // index of slot 0 of a chain in the value store
   function automatic logic [IDX_W-1:0] chain_base(input logic [CHAIN_W-1:0] chain);
      if (chain < CHAIN_W'(4)) begin
         chain_base = IDX_W'({chain, 1'b0});
      end else if (chain == CHAIN_W'(4)) begin
         chain_base = IDX_W'(8);
      end else begin
         chain_base = IDX_W'(13);
      end
   endfunction

   function automatic logic [SLOT_W-1:0] chain_slots(input logic [CHAIN_W-1:0] chain);
      chain_slots = (chain < CHAIN_W'(4)) ? SLOT_W'(2) : SLOT_W'(5);
   endfunction

   // whole bytes of a frame
   function automatic logic [BYTE_IDX_W-1:0] frame_bytes(input logic [CHAIN_W-1:0] chain);
      frame_bytes = (chain < CHAIN_W'(4)) ? BYTE_IDX_W'(4) : BYTE_IDX_W'(9);
   endfunction

   // leading zero bits ahead of the first word
   function automatic logic [PAD_W-1:0] pad_bits(input logic [CHAIN_W-1:0] chain);
      pad_bits = (chain < CHAIN_W'(4)) ? PAD_W'(4) : PAD_W'(2);
   endfunction

   function automatic logic [ADDR_BITS-1:0] reverse4(input logic [ADDR_BITS-1:0] a);
      reverse4 = {a[0], a[1], a[2], a[3]};
   endfunction

endpackage

`default_nettype wire

// ===== design/dac_chain_frame_packer_unit.sv =====
// dac_chain_frame_packer_unit: top level of the dac chain frame packer
// depends on dcfp_pkg for constants and the channel-to-chain mapping
`default_nettype none

// Each accepted word stores a new value for one of 18 dac channels and then
// sends the whole frame of the chain that channel belongs to, one byte per
// rsp word, first byte first. Channels 1-8 go in pairs to chains 0-3 (4-byte
// frames), channels 9-13 and 14-18 to chains 4 and 5 (9-byte frames). A
// channel outside 1-18 is stored nowhere and gives no rsp word. If any stored
// value of the chain is 1024 or more, one rsp word with range_error and
// last_byte set and frame_byte zero replaces the frame. The frame is built
// bit-serially: one bit per cycle, unless a stalled rsp side holds it, goes
// from a 14-bit word shift register into a byte shift register; the range
// check walks the chain one slot per cycle. One item is in work at a time;
// req_ready is high only between items. The rsp output register lets the
// serializer run on while a finished byte waits; a stalled rsp side holds
// the serializer only when the next byte is complete. csr_wr_data sets the
// dac address, sent bit-reversed in every word; write it only between items.

module dac_chain_frame_packer_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // configuration
   input  wire logic                               csr_wr_en,
   input  wire logic [dcfp_pkg::ADDR_BITS-1:0]     csr_wr_data,
   // request channel
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [dcfp_pkg::CHAN_W-1:0]        req_channel,
   input  wire logic [dcfp_pkg::VALUE_W-1:0]       req_value,
   // response channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [dcfp_pkg::CHAIN_W-1:0]            rsp_chain,
   output logic [7:0]                              rsp_frame_byte,
   output logic                                    rsp_last_byte,
   output logic                                    rsp_range_error
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ERROR,
      ST_SHIFT
   } state_type;

   localparam int unsigned IDX_W  = dcfp_pkg::IDX_W;
   localparam int unsigned SLOT_W = dcfp_pkg::SLOT_W;
   localparam int unsigned WORD_W = dcfp_pkg::WORD_BITS;

   // channel value store, all zero after reset
   logic [dcfp_pkg::VALUE_W-1:0]          vals_ff [dcfp_pkg::NUM_CHANNELS];

   logic [dcfp_pkg::ADDR_BITS-1:0]        chip_addr_ff;

   state_type                             state_ff, state_in;
   logic [dcfp_pkg::CHAIN_W-1:0]          chain_ff, chain_in;
   logic [IDX_W-1:0]                      base_ff, base_in;
   logic [SLOT_W-1:0]                     nslot_ff, nslot_in;
   logic [SLOT_W-1:0]                     slot_ff, slot_in;
   logic [WORD_W-1:0]                     word_sr_ff, word_sr_in;
   logic [dcfp_pkg::WBIT_W-1:0]           wbit_ff, wbit_in;
   logic [dcfp_pkg::PAD_W-1:0]            pad_ff, pad_in;
   logic [7:0]                            byte_sr_ff, byte_sr_in;
   logic [2:0]                            bitpos_ff, bitpos_in;
   logic [dcfp_pkg::BYTE_IDX_W-1:0]       byte_idx_ff, byte_idx_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [dcfp_pkg::CHAIN_W-1:0]          rsp_chain_ff, rsp_chain_in;
   logic [7:0]                            rsp_byte_ff, rsp_byte_in;
   logic                                  rsp_last_ff, rsp_last_in;
   logic                                  rsp_err_ff, rsp_err_in;

   logic                                  ch_ok;
   logic                                  store_en;
   logic [IDX_W-1:0]                      wr_idx;
   logic [IDX_W-1:0]                      rd_idx;
   logic [SLOT_W-1:0]                     rd_slot;
   logic [dcfp_pkg::VALUE_W-1:0]          rd_data;
   logic [WORD_W-1:0]                     rd_word;
   logic                                  out_free;
   logic                                  step;
   logic                                  bit_out;
   logic                                  byte_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign ch_ok     = (req_channel >= dcfp_pkg::CHAN_W'(1)) &&
                      (req_channel <= dcfp_pkg::CHAN_W'(dcfp_pkg::NUM_CHANNELS));
   assign store_en  = req_valid && req_ready && ch_ok;
   assign wr_idx    = IDX_W'(req_channel - dcfp_pkg::CHAN_W'(1));

   // one read port: the slot under check, or the next lower slot while shifting
   assign rd_slot = (state_ff == ST_SHIFT) ? (slot_ff - SLOT_W'(1)) : slot_ff;
   assign rd_idx  = base_ff + IDX_W'(rd_slot);
   assign rd_data = (rd_idx < IDX_W'(dcfp_pkg::NUM_CHANNELS)) ? vals_ff[rd_idx] : '0;
   assign rd_word = {dcfp_pkg::reverse4(chip_addr_ff), rd_data[dcfp_pkg::VALUE_BITS-1:0]};

   // the output register frees up when empty or being taken
   assign out_free = !rsp_valid_ff || rsp_ready;
   // stall only when the byte about to complete has nowhere to go
   assign step     = (bitpos_ff != 3'd7) || out_free;
   assign bit_out  = (pad_ff != '0) ? 1'b0 : word_sr_ff[WORD_W-1];
   assign byte_last = (byte_idx_ff == (dcfp_pkg::frame_bytes(chain_ff) -
                                       dcfp_pkg::BYTE_IDX_W'(1)));

   always_comb begin
      state_in     = state_ff;
      chain_in     = chain_ff;
      base_in      = base_ff;
      nslot_in     = nslot_ff;
      slot_in      = slot_ff;
      word_sr_in   = word_sr_ff;
      wbit_in      = wbit_ff;
      pad_in       = pad_ff;
      byte_sr_in   = byte_sr_ff;
      bitpos_in    = bitpos_ff;
      byte_idx_in  = byte_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_chain_in = rsp_chain_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;

      case (state_ff)
         ST_IDLE: begin
            if (store_en) begin
               chain_in = dcfp_pkg::chain_of(req_channel);
               base_in  = dcfp_pkg::chain_base(chain_in);
               nslot_in = dcfp_pkg::chain_slots(chain_in);
               slot_in  = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // range check, one slot per cycle
            if (rd_data[dcfp_pkg::VALUE_W-1:dcfp_pkg::VALUE_BITS] != '0) begin
               state_in = ST_ERROR;
            end else if (slot_ff == nslot_ff - SLOT_W'(1)) begin
               // highest slot goes out first
               word_sr_in  = rd_word;
               wbit_in     = '0;
               pad_in      = dcfp_pkg::pad_bits(chain_ff);
               bitpos_in   = '0;
               byte_idx_in = '0;
               state_in    = ST_SHIFT;
            end else begin
               slot_in = slot_ff + SLOT_W'(1);
            end
         end
         ST_ERROR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_chain_in = chain_ff;
               rsp_byte_in  = '0;
               rsp_last_in  = 1'b1;
               rsp_err_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SHIFT: begin
            if (step) begin
               if (pad_ff != '0) begin
                  pad_in = pad_ff - dcfp_pkg::PAD_W'(1);
               end else begin
                  word_sr_in = {word_sr_ff[WORD_W-2:0], 1'b0};
                  if (wbit_ff == dcfp_pkg::WBIT_W'(WORD_W - 1)) begin
                     wbit_in = '0;
                     if (slot_ff != '0) begin
                        slot_in    = slot_ff - SLOT_W'(1);
                        word_sr_in = rd_word;
                     end
                  end else begin
                     wbit_in = wbit_ff + dcfp_pkg::WBIT_W'(1);
                  end
               end
               byte_sr_in = {byte_sr_ff[6:0], bit_out};
               bitpos_in  = bitpos_ff + 3'd1;
               if (bitpos_ff == 3'd7) begin
                  rsp_valid_in = 1'b1;
                  rsp_chain_in = chain_ff;
                  rsp_byte_in  = byte_sr_in;
                  rsp_last_in  = byte_last;
                  rsp_err_in   = 1'b0;
                  byte_idx_in  = byte_idx_ff + dcfp_pkg::BYTE_IDX_W'(1);
                  if (byte_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         chip_addr_ff <= '0;
         for (int i = 0; i < dcfp_pkg::NUM_CHANNELS; i++) begin
            vals_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            chip_addr_ff <= csr_wr_data;
         end
         if (store_en) begin
            vals_ff[wr_idx] <= req_value;
         end
      end
      chain_ff     <= chain_in;
      base_ff      <= base_in;
      nslot_ff     <= nslot_in;
      slot_ff      <= slot_in;
      word_sr_ff   <= word_sr_in;
      wbit_ff      <= wbit_in;
      pad_ff       <= pad_in;
      byte_sr_ff   <= byte_sr_in;
      bitpos_ff    <= bitpos_in;
      byte_idx_ff  <= byte_idx_in;
      rsp_chain_ff <= rsp_chain_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_chain       = rsp_chain_ff;
   assign rsp_frame_byte  = rsp_byte_ff;
   assign rsp_last_byte   = rsp_last_ff;
   assign rsp_range_error = rsp_err_ff;

endmodule

`default_nettype wire
